// File: rtl/gitt_pkg.sv
// Package: shared types, sizes and register codes of the greedy IOU track table.
`timescale 1ns / 1ps
package gitt_pkg;

  localparam int MAX_TRACKS = 32;
  localparam int MAX_DETS   = 32;

  localparam int TAW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int TCW = $clog2(MAX_TRACKS + 1);
  localparam int DAW = (MAX_DETS > 1) ? $clog2(MAX_DETS) : 1;
  localparam int DCW = $clog2(MAX_DETS + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_IOU_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MISS_LIMIT    = 1'd1;

  localparam logic [15:0] IOU_THRESHOLD_RST = 16'd19661;
  localparam logic [7:0]  MISS_LIMIT_RST    = 8'd5;

  typedef struct packed {
    logic        [15:0] h;
    logic        [15:0] w;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } box_t;

  typedef struct packed {
    logic [7:0]  miss;
    logic [15:0] age;
    logic [31:0] id;
    box_t        box;
  } trk_row_t;

  typedef struct packed {
    logic        done;
    logic        better;
    logic [31:0] inter;
    logic [32:0] uni;
  } iou_res_t;

  localparam int ROW_W = $bits(trk_row_t);
  localparam int BOX_W = $bits(box_t);

endpackage

// File: rtl/gitt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module gitt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                           clk,
  input  logic                                           we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                               wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/gitt_iou.sv
// Multi-cycle IOU unit: compares one pair's IOU against the running best.
`timescale 1ns / 1ps
module gitt_iou (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  gitt_pkg::box_t     tbox,
  input  gitt_pkg::box_t     dbox,
  input  logic [31:0]        bn,
  input  logic [32:0]        bd,
  output gitt_pkg::iou_res_t res
);

  typedef enum logic [3:0] {
    I_IDLE, I_EDGE, I_INTER, I_TAREA, I_DAREA, I_UNI, I_P1, I_P2, I_CMP
  } ist_t;

  ist_t        state_r;
  logic [15:0] iw_r, ih_r;
  logic [31:0] inter_r, ta_r, da_r;
  logic [32:0] uni_r;
  logic [64:0] p1_r, p2_r;
  logic        done_r, better_r;

  logic signed [15:0] x1, y1;
  logic signed [17:0] tx2, dx2, ty2, dy2, x2, y2, dx, dy;

  always_comb begin
    x1  = (tbox.x > dbox.x) ? tbox.x : dbox.x;
    y1  = (tbox.y > dbox.y) ? tbox.y : dbox.y;
    tx2 = {{2{tbox.x[15]}}, tbox.x} + $signed({2'b00, tbox.w});
    dx2 = {{2{dbox.x[15]}}, dbox.x} + $signed({2'b00, dbox.w});
    ty2 = {{2{tbox.y[15]}}, tbox.y} + $signed({2'b00, tbox.h});
    dy2 = {{2{dbox.y[15]}}, dbox.y} + $signed({2'b00, dbox.h});
    x2  = (tx2 < dx2) ? tx2 : dx2;
    y2  = (ty2 < dy2) ? ty2 : dy2;
    dx  = x2 - {{2{x1[15]}}, x1};
    dy  = y2 - {{2{y1[15]}}, y1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= I_IDLE;
      done_r   <= 1'b0;
      better_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        I_IDLE:  if (start) state_r <= I_EDGE;
        I_EDGE: begin
          iw_r    <= (dx > 18'sd0) ? dx[15:0] : 16'd0;
          ih_r    <= (dy > 18'sd0) ? dy[15:0] : 16'd0;
          state_r <= I_INTER;
        end
        I_INTER: begin
          inter_r <= iw_r * ih_r;
          state_r <= I_TAREA;
        end
        I_TAREA: begin
          ta_r    <= tbox.w * tbox.h;
          state_r <= I_DAREA;
        end
        I_DAREA: begin
          da_r    <= dbox.w * dbox.h;
          state_r <= I_UNI;
        end
        I_UNI: begin
          uni_r   <= {1'b0, ta_r} + {1'b0, da_r} - {1'b0, inter_r};
          state_r <= I_P1;
        end
        I_P1: begin
          p1_r    <= inter_r * bd;
          state_r <= I_P2;
        end
        I_P2: begin
          p2_r    <= bn * uni_r;
          state_r <= I_CMP;
        end
        I_CMP: begin
          // zero union means IOU zero, never a match
          better_r <= (uni_r != 33'd0) && (p1_r > p2_r);
          done_r   <= 1'b1;
          state_r  <= I_IDLE;
        end
        default: state_r <= I_IDLE;
      endcase
    end
  end

  assign res.done   = done_r;
  assign res.better = better_r;
  assign res.inter  = inter_r;
  assign res.uni    = uni_r;

endmodule

// File: rtl/greedy_iou_track_table.sv
// Top level: frame collection, greedy matching, table compaction and track list output.
`timescale 1ns / 1ps
//  channel | direction | tdata (low bit up)              | tuser              | tlast
//  in_     | slave     | det_x, det_y, det_w, det_h      | has_box            | frame_last
//  out_    | master    | track_id, x, y, w, h, age, miss | track_present, ovf | list_last
//  cfg_    | slave     | cfg_index, cfg_data             | -                  | -
//
// Items without frame_last are taken in S_IN. A frame end runs greedy passes: each
// pass scans every open track against every unused detection, one pair at a time in
// the shared IOU unit, one pass per match plus a final one. Compaction reads, then
// writes each track; new tracks check, then write each detection; output reads, loads
// and holds each track until taken. Reset clears control state only; no memory sweep.
// in_tready is low from frame end until the last result is taken.
module greedy_iou_track_table (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [63:0]                     in_tdata,  // det_x, det_y, det_w, det_h
  input  logic                            in_tuser,  // has_box
  input  logic                            in_tlast,  // frame_last
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [119:0]                    out_tdata, // track_id, trk_x, trk_y, trk_w,
                                                     // trk_h, track_age, miss_count
  output logic [1:0]                      out_tuser, // track_present, overflow
  output logic                            out_tlast, // list_last
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gitt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gitt_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int TAW = gitt_pkg::TAW;
  localparam int TCW = gitt_pkg::TCW;
  localparam int DAW = gitt_pkg::DAW;
  localparam int DCW = gitt_pkg::DCW;

  typedef enum logic [3:0] {
    S_IN, S_M_TRD, S_M_TWAIT, S_M_DRD, S_M_DWAIT, S_M_IOU, S_M_APPLY,
    S_C_RD, S_C_WR, S_N_CHK, S_N_WR, S_O_RD, S_O_LD, S_O_WAIT
  } st_t;

  st_t                         state_r;
  logic [15:0]                 thr_r;
  logic [7:0]                  lim_r;
  logic [TCW-1:0]              tc_r, t_r, n_r, k_r;
  logic [DCW-1:0]              fc_r, d_r;
  logic [TAW-1:0]              bt_r;
  logic [DAW-1:0]              bdet_r;
  logic                        found_r, ovf_r, last_r;
  logic [31:0]                 bn_r, next_id_r;
  logic [32:0]                 bd_r;
  gitt_pkg::box_t              best_box_r, dbox_r;
  gitt_pkg::trk_row_t          trow_r, best_row_r;
  logic [gitt_pkg::MAX_TRACKS-1:0] t_done_r;
  logic [gitt_pkg::MAX_DETS-1:0]   d_used_r;
  logic                        out_valid_r, out_present_r, out_ovf_r;
  gitt_pkg::trk_row_t          out_row_r;
  logic                        iou_start;
  gitt_pkg::iou_res_t          iou_res;

  logic                        trk_we, frm_we;
  logic [TAW-1:0]              trk_waddr, trk_raddr;
  logic [DAW-1:0]              frm_waddr, frm_raddr;
  gitt_pkg::trk_row_t          trk_wdata, trk_rdata, crow;
  logic [gitt_pkg::ROW_W-1:0]  trk_rbits;
  logic [gitt_pkg::BOX_W-1:0]  frm_rbits;
  gitt_pkg::box_t              frm_rdata;
  logic                        in_acc, keep;

  assign in_tready = (state_r == S_IN);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign trk_rdata = gitt_pkg::trk_row_t'(trk_rbits);
  assign frm_rdata = gitt_pkg::box_t'(frm_rbits);
  assign iou_start = (state_r == S_M_DWAIT);

  // compaction: age and miss the unmatched row, then decide whether it survives
  always_comb begin
    crow = trk_rdata;
    if (!t_done_r[t_r[TAW-1:0]]) begin
      if (crow.miss != 8'hFF)    crow.miss = crow.miss + 8'd1;
      if (crow.age != 16'hFFFF)  crow.age  = crow.age + 16'd1;
    end
    keep = (crow.miss <= lim_r);
  end

  always_comb begin
    trk_we    = 1'b0;
    trk_waddr = bt_r;
    trk_wdata = crow;
    trk_raddr = t_r[TAW-1:0];
    frm_we    = in_acc && in_tuser && (fc_r < DCW'(gitt_pkg::MAX_DETS));
    frm_waddr = fc_r[DAW-1:0];
    frm_raddr = d_r[DAW-1:0];
    unique case (state_r)
      S_M_APPLY: begin
        trk_we        = 1'b1;
        trk_waddr     = bt_r;
        trk_wdata     = best_row_r;
        trk_wdata.box = best_box_r;
        trk_wdata.miss = 8'd0;
        if (best_row_r.age != 16'hFFFF) trk_wdata.age = best_row_r.age + 16'd1;
      end
      S_C_WR: begin
        trk_we    = keep;
        trk_waddr = n_r[TAW-1:0];
        trk_wdata = crow;
      end
      S_N_WR: begin
        trk_we         = 1'b1;
        trk_waddr      = tc_r[TAW-1:0];
        trk_wdata.box  = frm_rdata;
        trk_wdata.id   = next_id_r;
        trk_wdata.age  = 16'd1;
        trk_wdata.miss = 8'd0;
      end
      S_O_RD:  trk_raddr = k_r[TAW-1:0];
      default: ;
    endcase
  end

  gitt_ram #(.WIDTH(gitt_pkg::ROW_W), .DEPTH(gitt_pkg::MAX_TRACKS)) u_trk_ram (
    .clk(clk), .we(trk_we), .waddr(trk_waddr), .wdata(trk_wdata),
    .raddr(trk_raddr), .rdata(trk_rbits)
  );

  gitt_ram #(.WIDTH(gitt_pkg::BOX_W), .DEPTH(gitt_pkg::MAX_DETS)) u_frm_ram (
    .clk(clk), .we(frm_we), .waddr(frm_waddr), .wdata(in_tdata),
    .raddr(frm_raddr), .rdata(frm_rbits)
  );

  gitt_iou u_iou (
    .clk(clk), .rst_n(rst_n), .start(iou_start), .tbox(trow_r.box), .dbox(dbox_r),
    .bn(bn_r), .bd(bd_r), .res(iou_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IN;
      thr_r       <= gitt_pkg::IOU_THRESHOLD_RST;
      lim_r       <= gitt_pkg::MISS_LIMIT_RST;
      tc_r        <= '0;
      fc_r        <= '0;
      ovf_r       <= 1'b0;
      next_id_r   <= 32'd0;
      t_done_r    <= '0;
      d_used_r    <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          gitt_pkg::REG_IOU_THRESHOLD: thr_r <= cfg_data;
          gitt_pkg::REG_MISS_LIMIT:    lim_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IN: begin
          if (in_acc) begin
            if (in_tuser) begin
              if (fc_r < DCW'(gitt_pkg::MAX_DETS)) fc_r <= fc_r + 1'b1;
              else                                 ovf_r <= 1'b1;
            end
            if (in_tlast) begin
              bn_r    <= {16'd0, thr_r};
              bd_r    <= 33'd65536;
              found_r <= 1'b0;
              t_r     <= '0;
              state_r <= S_M_TRD;
            end
          end
        end
        S_M_TRD: begin
          if (t_r >= tc_r) begin
            if (found_r) begin
              state_r <= S_M_APPLY;
            end else begin
              t_r     <= '0;
              n_r     <= '0;
              state_r <= S_C_RD;
            end
          end else if (t_done_r[t_r[TAW-1:0]]) begin
            t_r <= t_r + 1'b1;
          end else begin
            state_r <= S_M_TWAIT;
          end
        end
        S_M_TWAIT: begin
          trow_r  <= trk_rdata;
          d_r     <= '0;
          state_r <= S_M_DRD;
        end
        S_M_DRD: begin
          if (d_r >= fc_r) begin
            t_r     <= t_r + 1'b1;
            state_r <= S_M_TRD;
          end else if (d_used_r[d_r[DAW-1:0]]) begin
            d_r <= d_r + 1'b1;
          end else begin
            state_r <= S_M_DWAIT;
          end
        end
        S_M_DWAIT: begin
          dbox_r  <= frm_rdata;
          state_r <= S_M_IOU;
        end
        S_M_IOU: begin
          if (iou_res.done) begin
            if (iou_res.better) begin
              bn_r       <= iou_res.inter;
              bd_r       <= iou_res.uni;
              bt_r       <= t_r[TAW-1:0];
              bdet_r     <= d_r[DAW-1:0];
              best_box_r <= dbox_r;
              best_row_r <= trow_r;
              found_r    <= 1'b1;
            end
            d_r     <= d_r + 1'b1;
            state_r <= S_M_DRD;
          end
        end
        S_M_APPLY: begin
          t_done_r[bt_r]   <= 1'b1;
          d_used_r[bdet_r] <= 1'b1;
          bn_r    <= {16'd0, thr_r};
          bd_r    <= 33'd65536;
          found_r <= 1'b0;
          t_r     <= '0;
          state_r <= S_M_TRD;
        end
        S_C_RD: begin
          if (t_r >= tc_r) begin
            tc_r    <= n_r;
            d_r     <= '0;
            state_r <= S_N_CHK;
          end else begin
            state_r <= S_C_WR;
          end
        end
        S_C_WR: begin
          if (keep) n_r <= n_r + 1'b1;
          t_r     <= t_r + 1'b1;
          state_r <= S_C_RD;
        end
        S_N_CHK: begin
          if (d_r >= fc_r) begin
            k_r     <= '0;
            state_r <= S_O_RD;
          end else if (d_used_r[d_r[DAW-1:0]]) begin
            d_r <= d_r + 1'b1;
          end else if (tc_r >= TCW'(gitt_pkg::MAX_TRACKS)) begin
            ovf_r <= 1'b1;
            d_r   <= d_r + 1'b1;
          end else begin
            state_r <= S_N_WR;
          end
        end
        S_N_WR: begin
          next_id_r <= next_id_r + 32'd1;
          tc_r      <= tc_r + 1'b1;
          d_r       <= d_r + 1'b1;
          state_r   <= S_N_CHK;
        end
        S_O_RD: begin
          if (tc_r == '0) begin
            out_row_r     <= '0;
            out_present_r <= 1'b0;
            out_ovf_r     <= ovf_r;
            last_r        <= 1'b1;
            out_valid_r   <= 1'b1;
            state_r       <= S_O_WAIT;
          end else begin
            state_r <= S_O_LD;
          end
        end
        S_O_LD: begin
          out_row_r     <= trk_rdata;
          out_present_r <= 1'b1;
          out_ovf_r     <= ovf_r;
          last_r        <= (k_r + 1'b1 == tc_r);
          out_valid_r   <= 1'b1;
          state_r       <= S_O_WAIT;
        end
        S_O_WAIT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            if (last_r) begin
              fc_r     <= '0;
              ovf_r    <= 1'b0;
              t_done_r <= '0;
              d_used_r <= '0;
              state_r  <= S_IN;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_O_RD;
            end
          end
        end
        default: state_r <= S_IN;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_row_r.miss, out_row_r.age, out_row_r.box.h, out_row_r.box.w,
                       out_row_r.box.y, out_row_r.box.x, out_row_r.id};
  assign out_tuser  = {out_ovf_r, out_present_r};
  assign out_tlast  = last_r;

  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid) else $error("input taken while a result is pending");
  a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= DCW'(gitt_pkg::MAX_DETS)) else $error("frame count beyond capacity");
  a_tc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tc_r <= TCW'(gitt_pkg::MAX_TRACKS)) else $error("track count beyond capacity");
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> out_tlast) else $error("empty list not last");

endmodule
